@@ hdl/tsa_pkg.sv @@
// Shared types, codes and helpers for the touch slot allocator.
package tsa_pkg;

  // Event codes on the input side
  localparam logic [1:0] ACT_BEGIN  = 2'd0;
  localparam logic [1:0] ACT_MOVE   = 2'd1;
  localparam logic [1:0] ACT_END    = 2'd2;
  localparam logic [1:0] ACT_CANCEL = 2'd3;

  // Event codes on the result side
  localparam logic [1:0] EV_BEGAN     = 2'd0;
  localparam logic [1:0] EV_MOVED     = 2'd1;
  localparam logic [1:0] EV_ENDED     = 2'd2;
  localparam logic [1:0] EV_CANCELLED = 2'd3;

  // Index width covers up to 32 slot cells; the reported slot field covers 8 slots
  localparam int SLOT_IDX_W = 5;
  localparam int SLOT_W     = 3;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] touch_id;
    logic [15:0]        x_pos;
    logic [15:0]        y_pos;
  } tsa_in_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [SLOT_W-1:0] slot;
    logic [15:0] out_x;
    logic [15:0] out_y;
  } tsa_out_t;

  // Lookup token that walks the row of slot cells
  typedef struct packed {
    logic                  valid;
    logic [1:0]            action;
    logic signed [31:0]    touch_id;
    logic [15:0]           x_pos;
    logic [15:0]           y_pos;
    logic                  hit;
    logic [SLOT_IDX_W-1:0] hit_idx;
    logic                  free;
    logic [SLOT_IDX_W-1:0] free_idx;
  } tsa_tok_t;

  // Slot update broadcast to every cell at the end of a lookup
  typedef struct packed {
    logic                  set;
    logic                  clr;
    logic [SLOT_IDX_W-1:0] idx;
    logic signed [31:0]    touch_id;
  } tsa_wr_t;

  function automatic logic [1:0] act_to_kind(input logic [1:0] act);
    logic [1:0] kind;
    unique case (act)
      ACT_BEGIN:  kind = EV_BEGAN;
      ACT_MOVE:   kind = EV_MOVED;
      ACT_END:    kind = EV_ENDED;
      ACT_CANCEL: kind = EV_CANCELLED;
      default:    kind = EV_BEGAN;
    endcase
    return kind;
  endfunction

endpackage

@@ hdl/tsa_cell.sv @@
// One slot cell: holds occupancy and id, updates the passing lookup token.
module tsa_cell #(
  parameter int CELL_INDEX = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  tsa_pkg::tsa_tok_t tok_in,
  input  tsa_pkg::tsa_wr_t  wr,
  output tsa_pkg::tsa_tok_t tok_out
);

  localparam logic [tsa_pkg::SLOT_IDX_W-1:0] MY_IDX = tsa_pkg::SLOT_IDX_W'(CELL_INDEX);

  logic               used;
  logic signed [31:0] id;
  logic               match;
  tsa_pkg::tsa_tok_t  tok_next;

  always_comb begin
    match    = used && (tok_in.touch_id == id);
    tok_next = tok_in;
    // Lowest slot wins: only claim when no earlier cell has
    if (!tok_in.hit && match) begin
      tok_next.hit     = 1'b1;
      tok_next.hit_idx = MY_IDX;
    end
    if (!tok_in.free && !used) begin
      tok_next.free     = 1'b1;
      tok_next.free_idx = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used    <= 1'b0;
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
      if (wr.set && wr.idx == MY_IDX) begin
        used <= 1'b1;
      end else if (wr.clr && wr.idx == MY_IDX) begin
        used <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.set && wr.idx == MY_IDX) begin
      id <= wr.touch_id;
    end
  end

endmodule

@@ hdl/touch_slot_allocator.sv @@
// Touch slot allocator: maps touch ids to the lowest free slot and reports events.
//
// Input channel (in_valid/in_ready/in_data) takes one touch event per transfer:
// begin, move, end or cancel with a touch id and a pixel position. Output
// channel (out_valid/out_ready/out_data) gives zero or one result per event.
//
// Each event walks a row of MAX_SLOTS slot cells, one cell per cycle: the token
// passes the launch register and then every cell register before the slot update;
// the result is registered onto out_valid at that same edge. A new event is taken
// only once the walk through the cell row is done. One event is in flight at a time.
//
// A finished result waits in the output register while the next event is
// taken; a second result is held in a spare register, and input is refused
// until that spare register drains.
//
// Reset (rst, synchronous) frees every slot and empties both channels.
module touch_slot_allocator #(
  parameter int MAX_SLOTS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  tsa_pkg::tsa_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output tsa_pkg::tsa_out_t out_data
);

  tsa_pkg::tsa_tok_t tok [MAX_SLOTS+1];
  tsa_pkg::tsa_wr_t  wr;
  tsa_pkg::tsa_tok_t t;
  tsa_pkg::tsa_out_t res;
  tsa_pkg::tsa_out_t pend_data;

  logic                            busy;
  logic                            pend_valid;
  logic                            in_fire;
  logic                            out_fire;
  logic                            is_begin;
  logic                            res_hit;
  logic                            res_valid;
  logic [tsa_pkg::SLOT_IDX_W-1:0]  res_idx;

  assign in_ready = !busy && !pend_valid;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // Launch the lookup token into the first cell
  always_ff @(posedge clk) begin
    if (rst) begin
      tok[0] <= '0;
      busy   <= 1'b0;
    end else begin
      tok[0].valid    <= in_fire;
      tok[0].action   <= in_data.action;
      tok[0].touch_id <= in_data.touch_id;
      tok[0].x_pos    <= in_data.x_pos;
      tok[0].y_pos    <= in_data.y_pos;
      tok[0].hit      <= 1'b0;
      tok[0].hit_idx  <= '0;
      tok[0].free     <= 1'b0;
      tok[0].free_idx <= '0;
      if (in_fire) begin
        busy <= 1'b1;
      end else if (t.valid) begin
        busy <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_cell
    tsa_cell #(
      .CELL_INDEX(i)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .tok_in (tok[i]),
      .wr     (wr),
      .tok_out(tok[i+1])
    );
  end

  // Decide at the end of the row
  always_comb begin
    t         = tok[MAX_SLOTS];
    is_begin  = (t.action == tsa_pkg::ACT_BEGIN);
    res_hit   = is_begin ? (!t.hit && t.free) : t.hit;
    res_idx   = is_begin ? t.free_idx : t.hit_idx;
    res_valid = t.valid && res_hit;

    wr.set      = res_valid && is_begin;
    wr.clr      = res_valid && (t.action == tsa_pkg::ACT_END ||
                                t.action == tsa_pkg::ACT_CANCEL);
    wr.idx      = res_idx;
    wr.touch_id = t.touch_id;

    res.event_kind = tsa_pkg::act_to_kind(t.action);
    res.slot       = res_idx[tsa_pkg::SLOT_W-1:0];
    res.out_x      = t.x_pos;
    res.out_y      = t.y_pos;
  end

  // Output register with a spare stage behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (out_fire || !out_valid) begin
      if (pend_valid) begin
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else begin
        out_valid <= res_valid;
      end
    end else if (res_valid) begin
      pend_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire || !out_valid) begin
      if (pend_valid) begin
        out_data <= pend_data;
      end else if (res_valid) begin
        out_data <= res;
      end
    end else if (res_valid) begin
      pend_data <= res;
    end
  end

endmodule

@@ hdl/tsa_checker.sv @@
// Port-level checks for the touch slot allocator, bound to the top level.
module tsa_checker #(
  parameter int MAX_SLOTS = 8
) (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input tsa_pkg::tsa_in_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input tsa_pkg::tsa_out_t out_data
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // Hold an offered event until its transfer
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("offered event changed or withdrawn");

  // Refuse input right after a transfer
  a_busy_after: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a lookup is in flight");

  // Still refusing input when the token reaches the end of the row
  a_busy_walk: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> ##(MAX_SLOTS+1) !in_ready)
    else $error("input taken before the slot walk finished");

  // A fresh result never follows an input transfer directly
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("result appeared too soon after an input transfer");

endmodule

bind touch_slot_allocator tsa_checker #(
  .MAX_SLOTS(MAX_SLOTS)
) u_tsa_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

@@ dv/tsa_tb_pkg.sv @@
// Scoreboard for the touch slot allocator: slot tracking and result checking.
`timescale 1ns / 1ps
package tsa_tb_pkg;

  localparam int NUM_SLOTS = 8;

  class slot_tracker;
    logic [NUM_SLOTS-1:0] used_mask;
    logic [31:0]          held_id [NUM_SLOTS];
    tsa_pkg::tsa_out_t    expected_results [$];
    int                   mismatches;

    function new();
      used_mask  = '0;
      mismatches = 0;
      foreach (held_id[i]) held_id[i] = '0;
    endfunction

    function int find_held(logic [31:0] id);
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (used_mask[i] && held_id[i] == id) return i;
      end
      return -1;
    endfunction

    function int find_free();
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (!used_mask[i]) return i;
      end
      return -1;
    endfunction

    function bit holds(logic [31:0] id);
      return find_held(id) >= 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // Update the slot state for an accepted event; return 1 when it yields a result.
    function bit note_event(tsa_pkg::tsa_in_t ev);
      int                hit;
      int                free_idx;
      tsa_pkg::tsa_out_t res;
      hit       = find_held(ev.touch_id);
      res.out_x = ev.x_pos;
      res.out_y = ev.y_pos;
      if (ev.action == tsa_pkg::ACT_BEGIN) begin
        if (hit >= 0) return 0;
        free_idx = find_free();
        if (free_idx < 0) return 0;
        used_mask[free_idx] = 1'b1;
        held_id[free_idx]   = ev.touch_id;
        res.event_kind      = tsa_pkg::EV_BEGAN;
        res.slot            = 3'(free_idx);
      end else begin
        if (hit < 0) return 0;
        res.slot = 3'(hit);
        case (ev.action)
          tsa_pkg::ACT_MOVE: begin
            res.event_kind = tsa_pkg::EV_MOVED;
          end
          tsa_pkg::ACT_END: begin
            res.event_kind = tsa_pkg::EV_ENDED;
            used_mask[hit] = 1'b0;
          end
          default: begin
            res.event_kind = tsa_pkg::EV_CANCELLED;
            used_mask[hit] = 1'b0;
          end
        endcase
      end
      expected_results.push_back(res);
      return 1;
    endfunction

    function void check_result(tsa_pkg::tsa_out_t got);
      tsa_pkg::tsa_out_t exp;
      if (expected_results.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: kind %0d slot %0d x %h y %h",
                   got.event_kind, got.slot, got.out_x, got.out_y);
        mismatches++;
        return;
      end
      exp = expected_results.pop_front();
      if (got.event_kind !== exp.event_kind || got.slot !== exp.slot ||
          got.out_x !== exp.out_x || got.out_y !== exp.out_y) begin
        if (mismatches < 10)
          $display("mismatch: expected kind %0d slot %0d x %h y %h, got kind %0d slot %0d x %h y %h",
                   exp.event_kind, exp.slot, exp.out_x, exp.out_y,
                   got.event_kind, got.slot, got.out_x, got.out_y);
        mismatches++;
      end
    endfunction
  endclass

endpackage

@@ dv/tb_top.sv @@
// Top-level testbench for the touch slot allocator: directed and random touch events.
`timescale 1ns / 1ps
module tb_top;

  localparam int POOL_SIZE   = 12;
  localparam int PHASE_ITEMS = 332;

  logic              clk;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  tsa_pkg::tsa_in_t  in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  tsa_pkg::tsa_out_t out_data;

  tsa_tb_pkg::slot_tracker tracker = new();

  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          hold_requests  = 0;
  int          holds_done     = 0;
  int          hold_left      = 0;
  logic [31:0] id_pool [POOL_SIZE];

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  touch_slot_allocator #(.MAX_SLOTS(tsa_tb_pkg::NUM_SLOTS)) DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Result side: check each transfer, then pick ready for the next cycle.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) tracker.check_result(out_data);
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (holds_done != hold_requests) begin
      holds_done++;
      hold_left = 300;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  function automatic tsa_pkg::tsa_in_t mk_event(logic [1:0] act, logic [31:0] id,
                                                logic [15:0] x, logic [15:0] y);
    tsa_pkg::tsa_in_t ev;
    ev.action   = act;
    ev.touch_id = id;
    ev.x_pos    = x;
    ev.y_pos    = y;
    return ev;
  endfunction

  function automatic logic [15:0] pick_coord();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'h0000;
    if (r < 20) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  function automatic tsa_pkg::tsa_in_t random_event();
    int          r;
    int          k;
    logic [1:0]  act;
    logic [31:0] id;
    // Swap out an idle pool id now and then, never one that holds a slot
    if ($urandom_range(0, 49) == 0) begin
      k = $urandom_range(0, POOL_SIZE - 1);
      if (!tracker.holds(id_pool[k])) id_pool[k] = $urandom;
    end
    r = $urandom_range(0, 99);
    if (r < 36)      act = tsa_pkg::ACT_BEGIN;
    else if (r < 66) act = tsa_pkg::ACT_MOVE;
    else if (r < 83) act = tsa_pkg::ACT_END;
    else             act = tsa_pkg::ACT_CANCEL;
    if ($urandom_range(0, 99) < 8) id = $urandom;
    else                           id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
    return mk_event(act, id, pick_coord(), pick_coord());
  endfunction

  // Offer one event after a random gap and hold it until the transfer.
  task automatic send_event(tsa_pkg::tsa_in_t ev);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= ev;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    void'(tracker.note_event(ev));
  endtask

  initial begin
    int wait_cycles;
    int failures;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Unknown ids, extreme ids and coordinates, fill to full, free and reuse
    send_event(mk_event(tsa_pkg::ACT_MOVE,   32'h0000_0000, 16'h0001, 16'h0002));
    send_event(mk_event(tsa_pkg::ACT_END,    32'h0000_0000, 16'h0003, 16'h0004));
    send_event(mk_event(tsa_pkg::ACT_CANCEL, 32'h0000_0000, 16'h0005, 16'h0006));
    send_event(mk_event(tsa_pkg::ACT_BEGIN,  32'h8000_0000, 16'h0000, 16'h0000));
    send_event(mk_event(tsa_pkg::ACT_BEGIN,  32'h7FFF_FFFF, 16'hFFFF, 16'hFFFF));
    send_event(mk_event(tsa_pkg::ACT_BEGIN,  32'h7FFF_FFFF, 16'h1111, 16'h2222));
    send_event(mk_event(tsa_pkg::ACT_BEGIN,  32'h0000_0000, 16'hAAAA, 16'h5555));
    send_event(mk_event(tsa_pkg::ACT_BEGIN,  32'hFFFF_FFFF, 16'h5555, 16'hAAAA));
    send_event(mk_event(tsa_pkg::ACT_BEGIN,  32'h0000_0001, 16'h0010, 16'h0020));
    send_event(mk_event(tsa_pkg::ACT_BEGIN,  32'h0000_0002, 16'h0030, 16'h0040));
    send_event(mk_event(tsa_pkg::ACT_BEGIN,  32'h0000_0003, 16'h0050, 16'h0060));
    send_event(mk_event(tsa_pkg::ACT_BEGIN,  32'h0000_0004, 16'h0070, 16'h0080));
    send_event(mk_event(tsa_pkg::ACT_BEGIN,  32'h0000_0005, 16'h0090, 16'h00A0));
    send_event(mk_event(tsa_pkg::ACT_MOVE,   32'h8000_0000, 16'hFFFF, 16'h0000));
    send_event(mk_event(tsa_pkg::ACT_END,    32'h7FFF_FFFF, 16'h0000, 16'hFFFF));
    send_event(mk_event(tsa_pkg::ACT_BEGIN,  32'h0000_0005, 16'h1234, 16'h5678));
    send_event(mk_event(tsa_pkg::ACT_CANCEL, 32'h0000_0000, 16'h8000, 16'h0001));
    send_event(mk_event(tsa_pkg::ACT_MOVE,   32'h0000_0000, 16'h0001, 16'h8000));
    send_event(mk_event(tsa_pkg::ACT_CANCEL, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
    send_event(mk_event(tsa_pkg::ACT_END,    32'h8000_0000, 16'h0000, 16'h0000));
    send_event(mk_event(tsa_pkg::ACT_BEGIN,  32'h0000_0006, 16'h7FFF, 16'h7FFF));
    send_event(mk_event(tsa_pkg::ACT_MOVE,   32'h0000_0005, 16'hFEDC, 16'h0123));

    // Seed the pool with the ids still holding slots so they get freed later
    for (int i = 0; i < POOL_SIZE; i++) id_pool[i] = (i < 6) ? 32'(i + 1) : $urandom;

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          hold_requests++;
        end
        1: begin
          send_idle_pct  = 81;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 81;
        end
        default: begin
          send_idle_pct  = 19;
          recv_stall_pct = 19;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) send_event(random_event());
    end
    in_valid <= 1'b0;

    wait_cycles = 0;
    while (tracker.pending() > 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (20) @(posedge clk);

    failures = tracker.mismatches + tracker.pending();
    if (tracker.pending() > 0)
      $display("%0d expected results never arrived", tracker.pending());
    if (failures == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
